>>> hdl/alth_pkg.sv
package alth_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int SIZE_BITS_DEF     = 48;
    localparam int ADDR_W            = 64;
    localparam int IN_SIZE_W         = 48;
    localparam int SLOT_W            = 12;
    localparam int LIVE_W            = 13;
    localparam int TOTAL_W           = 64;
    localparam int HASH_STAGES       = 4;
    localparam int Q_DEPTH           = 2;

    localparam logic CMD_RECORD  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef struct packed {
        logic                 cmd;
        logic [ADDR_W-1:0]    address;
        logic [IN_SIZE_W-1:0] alloc_size;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot_index;
        logic [IN_SIZE_W-1:0] released_size;
        logic [TOTAL_W-1:0]   total_bytes;
        logic [LIVE_W-1:0]    live_count;
    } rsp_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_SHIFT,
        B_SHASH,
        B_FINISH,
        B_EMIT
    } back_state_t;

    // two of the eight integer-hash steps per pipeline stage
    function automatic logic [63:0] wang_stage(input logic [63:0] h, input logic [1:0] s);
        logic [63:0] t;
        t = h;
        unique case (s)
            2'd0:
            begin
                t = t + ~(t << 32);
                t = t ^ (t >> 22);
            end
            2'd1:
            begin
                t = t + ~(t << 13);
                t = t ^ (t >> 8);
            end
            2'd2:
            begin
                t = t + (t << 3);
                t = t ^ (t >> 15);
            end
            2'd3:
            begin
                t = t + ~(t << 27);
                t = t ^ (t >> 31);
            end
            default:
            begin
                t = h;
            end
        endcase
        return t;
    endfunction

endpackage

>>> hdl/allocation_tracking_hash_table_unit.sv
// Allocation tracking table: open-addressed, linear probing, backward-shift delete.
// Request channel: push/full with req (cmd, address, alloc_size); a request is
// taken at a clock edge with push high and full low.
// Result channel: empty/pop with rsp; one result per request, in request order,
// taken at a clock edge with pop high and empty low.
// Config: cfg_we/cfg_wdata write track_enable (reset 1); write only when idle.
// Flow: the front takes a request, runs its address through the hash pipeline
// and pushes it with its home slot into the middle queue; the back engine then
// takes it, probes slots from the home slot unless tracking is off or the
// address is zero, and emits the result. A release that finds its key also
// compacts the cluster, reading each following slot and rehashing the moved
// key, then clears the last hole and updates the totals. The front takes a new
// request once it has pushed the last one and hashes it while the back is busy.
// After reset the back clears the key memory with full high; totals reset to zero.
// A stalled consumer fills the 2-entry result queue; the back then stops taking
// work, the 2-entry middle queue fills and full rises.
module allocation_tracking_hash_table_unit
    import alth_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int SIZE_BITS     = SIZE_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic empty,
    input  logic pop,
    output rsp_t rsp,
    input  logic cfg_we,
    input  logic cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int MID_W = IDX_W + $bits(req_t);

    logic             track_enable_reg;
    logic             clearing;
    logic             mid_push, mid_full, mid_pop, mid_empty;
    logic [MID_W-1:0] mid_wdata, mid_rdata;
    logic             out_push, out_full;
    rsp_t             out_data;
    logic [$bits(rsp_t)-1:0] out_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            track_enable_reg <= cfg_wdata;
        end
    end

    alth_front #(.IDX_W(IDX_W)) u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .hold    (clearing),
        .push    (push),
        .req     (req),
        .full    (full),
        .mid_push(mid_push),
        .mid_data(mid_wdata),
        .mid_full(mid_full)
    );

    alth_fifo #(.WIDTH(MID_W), .DEPTH(Q_DEPTH)) u_mid_q
    (
        .clk  (clk),
        .rst_n(rst_n),
        .push (mid_push),
        .wdata(mid_wdata),
        .full (mid_full),
        .pop  (mid_pop),
        .rdata(mid_rdata),
        .empty(mid_empty)
    );

    alth_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .SIZE_BITS(SIZE_BITS), .IDX_W(IDX_W)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .track_enable(track_enable_reg),
        .clearing    (clearing),
        .mid_empty   (mid_empty),
        .mid_data    (mid_rdata),
        .mid_pop     (mid_pop),
        .out_full    (out_full),
        .out_push    (out_push),
        .out_data    (out_data)
    );

    alth_fifo #(.WIDTH($bits(rsp_t)), .DEPTH(Q_DEPTH)) u_out_q
    (
        .clk  (clk),
        .rst_n(rst_n),
        .push (out_push),
        .wdata(out_data),
        .full (out_full),
        .pop  (pop),
        .rdata(out_rdata),
        .empty(empty)
    );

    assign rsp = rsp_t'(out_rdata);

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("request accepted during table clear");

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into full queue");

    a_mid_room: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> !mid_full)
        else $error("request pushed into full middle queue");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status != ST_OK) |-> (rsp.slot_index == '0 && rsp.released_size == '0))
        else $error("error result carries slot or size");

endmodule

>>> hdl/alth_fifo.sv
module alth_fifo
    import alth_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == DEPTH_C);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/alth_hash.sv
module alth_hash
    import alth_pkg::*;
#(
    parameter int IDX_W = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [ADDR_W-1:0] key,
    output logic              out_valid,
    output logic [IDX_W-1:0]  home
);

    logic [63:0] h_reg [HASH_STAGES];
    logic        v_reg [HASH_STAGES];

    always_ff @(posedge clk)
    begin
        h_reg[0] <= wang_stage(key, 2'd0);
        for (int s = 1; s < HASH_STAGES; s++)
        begin
            h_reg[s] <= wang_stage(h_reg[s-1], 2'(s));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < HASH_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < HASH_STAGES; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[HASH_STAGES-1];
    assign home      = h_reg[HASH_STAGES-1][IDX_W-1:0];

endmodule

>>> hdl/alth_front.sv
module alth_front
    import alth_pkg::*;
#(
    parameter int IDX_W = 12
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        hold,
    input  logic                        push,
    input  req_t                        req,
    output logic                        full,
    output logic                        mid_push,
    output logic [IDX_W+$bits(req_t)-1:0] mid_data,
    input  logic                        mid_full
);

    front_state_t     state_reg;
    front_state_t     state_next;
    req_t             req_reg;
    logic [IDX_W-1:0] home_reg;
    logic             accept;
    logic             h_valid;
    logic [IDX_W-1:0] h_home;

    assign accept = push && !full;

    alth_hash #(.IDX_W(IDX_W)) u_hash
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .key      (req.address),
        .out_valid(h_valid),
        .home     (h_home)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (accept)    state_next = F_HASH;
            F_HASH:  if (h_valid)   state_next = F_PUSH;
            F_PUSH:  if (!mid_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        full     = (state_reg != F_IDLE) || hold;
        mid_push = (state_reg == F_PUSH) && !mid_full;
        mid_data = {home_reg, req_reg};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (state_reg == F_HASH && h_valid)
        begin
            home_reg <= h_home;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/alth_back.sv
module alth_back
    import alth_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int SIZE_BITS     = SIZE_BITS_DEF,
    parameter int IDX_W         = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          track_enable,
    output logic                          clearing,
    input  logic                          mid_empty,
    input  logic [IDX_W+$bits(req_t)-1:0] mid_data,
    output logic                          mid_pop,
    input  logic                          out_full,
    output logic                          out_push,
    output rsp_t                          out_data
);

    localparam int SW = (SIZE_BITS < IN_SIZE_W) ? SIZE_BITS : IN_SIZE_W;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

    logic [ADDR_W-1:0] key_mem  [TABLE_ENTRIES];
    logic [SW-1:0]     size_mem [TABLE_ENTRIES];

    back_state_t       state_reg, state_next;
    logic              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SW-1:0]     size_reg, size_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  n_reg, n_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [SW-1:0]     rel_reg, rel_next;
    logic [63:0]       bytes_reg, bytes_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] shk_reg, shk_next;
    logic [SW-1:0]     shs_reg, shs_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;

    logic              key_we;
    logic [IDX_W-1:0]  key_wa;
    logic [ADDR_W-1:0] key_wd;
    logic              size_we;
    logic [SW-1:0]     size_wd;
    logic [IDX_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] key_q;
    logic [SW-1:0]     size_q;

    logic              h_start;
    logic              h_valid;
    logic [IDX_W-1:0]  h_home;
    logic              move;

    req_t              m_req;
    logic [IDX_W-1:0]  m_home;

    assign {m_home, m_req} = mid_data;

    alth_hash #(.IDX_W(IDX_W)) u_hash
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (h_start),
        .key      (key_q),
        .out_valid(h_valid),
        .home     (h_home)
    );

    // entry at j may move into the hole at i unless its home lies cyclically in (i, j]
    assign move = ((j_reg > i_reg) && ((h_home <= i_reg) || (h_home > j_reg))) ||
                  ((j_reg < i_reg) && ((h_home <= i_reg) && (h_home > j_reg)));

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        if (size_we)
        begin
            size_mem[key_wa] <= size_wd;
        end
        key_q  <= key_mem[rd_idx];
        size_q <= size_mem[rd_idx];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                if (clr_reg == LAST) state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (!mid_empty && !out_full)
                begin
                    if (!track_enable || m_req.address == '0)
                        state_next = B_EMIT;
                    else
                        state_next = B_PROBE;
                end
            end
            B_PROBE:
            begin
                if (cmd_reg == CMD_RECORD)
                begin
                    if (key_q == '0 || n_reg == LAST) state_next = B_EMIT;
                end
                else if (key_q == addr_reg)
                begin
                    state_next = B_SHIFT;
                end
                else if (key_q == '0 || n_reg == LAST)
                begin
                    state_next = B_EMIT;
                end
            end
            B_SHIFT:
            begin
                state_next = (key_q == '0) ? B_FINISH : B_SHASH;
            end
            B_SHASH:
            begin
                if (h_valid) state_next = (n_reg == LAST) ? B_FINISH : B_SHIFT;
            end
            B_FINISH: state_next = B_EMIT;
            B_EMIT:   state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        size_next   = size_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        rel_next    = rel_reg;
        bytes_next  = bytes_reg;
        count_next  = count_reg;
        shk_next    = shk_reg;
        shs_next    = shs_reg;
        clr_next    = clr_reg;
        key_we      = 1'b0;
        size_we     = 1'b0;
        key_wa      = i_reg;
        key_wd      = '0;
        size_wd     = size_reg;
        rd_idx      = i_reg;
        h_start     = 1'b0;
        mid_pop     = 1'b0;
        out_push    = 1'b0;
        clearing    = (state_reg == B_CLEAR);
        out_data.status        = status_reg;
        out_data.slot_index    = SLOT_W'(slot_reg);
        out_data.released_size = IN_SIZE_W'(rel_reg);
        out_data.total_bytes   = bytes_reg;
        out_data.live_count    = LIVE_W'(count_reg);

        unique case (state_reg)
            B_CLEAR:
            begin
                key_we   = 1'b1;
                key_wa   = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            B_IDLE:
            begin
                if (!mid_empty && !out_full)
                begin
                    mid_pop     = 1'b1;
                    cmd_next    = m_req.cmd;
                    addr_next   = m_req.address;
                    size_next   = m_req.alloc_size[SW-1:0];
                    status_next = ST_OK;
                    slot_next   = '0;
                    rel_next    = '0;
                    i_next      = m_home;
                    n_next      = '0;
                    rd_idx      = m_home;
                    if (track_enable && m_req.address == '0)
                        status_next = (m_req.cmd == CMD_RECORD) ? ST_NULL : ST_UNKNOWN;
                end
            end
            B_PROBE:
            begin
                if (cmd_reg == CMD_RECORD && key_q == '0)
                begin
                    key_we     = 1'b1;
                    size_we    = 1'b1;
                    key_wd     = addr_reg;
                    size_wd    = size_reg;
                    slot_next  = i_reg;
                    bytes_next = bytes_reg + 64'(size_reg);
                    count_next = count_reg + 1'b1;
                end
                else if (cmd_reg == CMD_RELEASE && key_q == addr_reg)
                begin
                    slot_next = i_reg;
                    rel_next  = size_q;
                    j_next    = i_reg + 1'b1;
                    n_next    = IDX_W'(1);
                    rd_idx    = i_reg + 1'b1;
                end
                else if (cmd_reg == CMD_RELEASE && key_q == '0)
                begin
                    status_next = ST_UNKNOWN;
                end
                else if (n_reg == LAST)
                begin
                    status_next = (cmd_reg == CMD_RECORD) ? ST_FULL : ST_UNKNOWN;
                end
                else
                begin
                    n_next = n_reg + 1'b1;
                    i_next = i_reg + 1'b1;
                    rd_idx = i_reg + 1'b1;
                end
            end
            B_SHIFT:
            begin
                shk_next = key_q;
                shs_next = size_q;
                h_start  = (key_q != '0);
            end
            B_SHASH:
            begin
                if (h_valid)
                begin
                    if (move)
                    begin
                        key_we  = 1'b1;
                        size_we = 1'b1;
                        key_wd  = shk_reg;
                        size_wd = shs_reg;
                        i_next  = j_reg;
                    end
                    if (n_reg != LAST)
                    begin
                        n_next = n_reg + 1'b1;
                        j_next = j_reg + 1'b1;
                        rd_idx = j_reg + 1'b1;
                    end
                end
            end
            B_FINISH:
            begin
                key_we     = 1'b1;
                bytes_next = bytes_reg - 64'(rel_reg);
                count_next = count_reg - 1'b1;
            end
            B_EMIT:
            begin
                out_push = 1'b1;
            end
            default:
            begin
                out_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        addr_reg <= addr_next;
        size_reg <= size_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        n_reg    <= n_next;
        slot_reg <= slot_next;
        rel_reg  <= rel_next;
        shk_reg  <= shk_next;
        shs_reg  <= shs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLEAR;
            status_reg <= ST_OK;
            bytes_reg  <= '0;
            count_reg  <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            bytes_reg  <= bytes_next;
            count_reg  <= count_next;
            clr_reg    <= clr_next;
        end
    end

endmodule

>>> tb/allocation_tracking_hash_table_unit_tb.sv
module allocation_tracking_hash_table_unit_tb
    import alth_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS = 4096;
    localparam int LIMIT_CYCLES = 1500000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    req_t req;
    logic empty;
    logic pop;
    rsp_t rsp;
    logic cfg_we;
    logic cfg_wdata;

    allocation_tracking_hash_table_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // table shadow
    logic [63:0] shadow_key [N_SLOTS];
    logic [47:0] shadow_size [N_SLOTS];
    logic [63:0] shadow_bytes;
    logic [12:0] shadow_live;
    logic        shadow_enable;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    logic [63:0] live_addrs[$];
    int error_count;
    int push_idle_pct;
    int pop_stall_pct;
    int cycle_count;

    function automatic logic [11:0] home_slot(input logic [63:0] a);
        logic [63:0] h;
        h = a;
        h = h + ~(h << 32);
        h = h ^ (h >> 22);
        h = h + ~(h << 13);
        h = h ^ (h >> 8);
        h = h + (h << 3);
        h = h ^ (h >> 15);
        h = h + ~(h << 27);
        h = h ^ (h >> 31);
        return h[11:0];
    endfunction

    function automatic rsp_t apply_request(input req_t r);
        rsp_t o;
        logic [11:0] i;
        logic [11:0] j;
        logic [11:0] k;
        logic found;
        o = '0;
        o.status = ST_OK;
        if (shadow_enable)
        begin
            if (r.cmd == CMD_RECORD)
            begin
                if (r.address == 64'd0)
                    o.status = ST_NULL;
                else
                begin
                    i = home_slot(r.address);
                    found = 1'b0;
                    for (int n = 0; n < N_SLOTS; n++)
                    begin
                        if (shadow_key[i] == 64'd0)
                        begin
                            found = 1'b1;
                            break;
                        end
                        i = i + 12'd1;
                    end
                    if (!found)
                        o.status = ST_FULL;
                    else
                    begin
                        shadow_key[i] = r.address;
                        shadow_size[i] = r.alloc_size;
                        shadow_bytes = shadow_bytes + 64'(r.alloc_size);
                        shadow_live = shadow_live + 13'd1;
                        o.slot_index = i;
                    end
                end
            end
            else
            begin
                i = home_slot(r.address);
                found = 1'b0;
                if (r.address != 64'd0)
                begin
                    for (int n = 0; n < N_SLOTS; n++)
                    begin
                        if (shadow_key[i] == r.address)
                        begin
                            found = 1'b1;
                            break;
                        end
                        if (shadow_key[i] == 64'd0)
                            break;
                        i = i + 12'd1;
                    end
                end
                if (!found)
                    o.status = ST_UNKNOWN;
                else
                begin
                    o.slot_index = i;
                    o.released_size = shadow_size[i];
                    j = i;
                    for (int n = 1; n < N_SLOTS; n++)
                    begin
                        j = j + 12'd1;
                        if (shadow_key[j] == 64'd0)
                            break;
                        k = home_slot(shadow_key[j]);
                        if ((j > i && (k <= i || k > j)) || (j < i && (k <= i && k > j)))
                        begin
                            shadow_key[i] = shadow_key[j];
                            shadow_size[i] = shadow_size[j];
                            i = j;
                        end
                    end
                    shadow_key[i] = 64'd0;
                    shadow_bytes = shadow_bytes - 64'(o.released_size);
                    shadow_live = shadow_live - 13'd1;
                end
            end
        end
        o.total_bytes = shadow_bytes;
        o.live_count = shadow_live;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                expected_rsps.push_back(apply_request(pending_reqs.pop_front()));
            end
            if ((!push || !full) && pending_reqs.size() > 0 &&
                $urandom_range(99) >= push_idle_pct)
            begin
                push <= 1'b1;
                req <= pending_reqs[0];
            end
            else if (!push || !full)
                push <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    error_count++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.status !== e.status)
                        report_mismatch("status", 64'(rsp.status), 64'(e.status));
                    if (rsp.slot_index !== e.slot_index)
                        report_mismatch("slot_index", 64'(rsp.slot_index), 64'(e.slot_index));
                    if (rsp.released_size !== e.released_size)
                        report_mismatch("released_size", 64'(rsp.released_size),
                                        64'(e.released_size));
                    if (rsp.total_bytes !== e.total_bytes)
                        report_mismatch("total_bytes", rsp.total_bytes, e.total_bytes);
                    if (rsp.live_count !== e.live_count)
                        report_mismatch("live_count", 64'(rsp.live_count), 64'(e.live_count));
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_request(input logic c, input logic [63:0] a, input logic [47:0] s);
        req_t r;
        r.cmd = c;
        r.address = a;
        r.alloc_size = s;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || push || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_enable(input logic v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        shadow_enable = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed traffic: records of random addresses, sometimes live ones, releases of live ones, some noise
    task automatic random_phase(input int count, input int addr_bits);
        logic [63:0] a;
        int pick;
        int sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 50 || live_addrs.size() == 0)
            begin
                a = {$urandom, $urandom};
                if (addr_bits < 64)
                    a = a & ((64'd1 << addr_bits) - 1);
                if ($urandom_range(9) == 0 && live_addrs.size() > 0)
                    a = live_addrs[$urandom_range(live_addrs.size() - 1)];
                add_request(CMD_RECORD, a, 48'({$urandom, $urandom}));
                if (a != 64'd0)
                    live_addrs.push_back(a);
            end
            else if (sel < 88)
            begin
                pick = $urandom_range(live_addrs.size() - 1);
                add_request(CMD_RELEASE, live_addrs[pick], 48'({$urandom, $urandom}));
                live_addrs.delete(pick);
            end
            else
                add_request(1'($urandom_range(1)), (sel < 92) ? 64'd0 : {$urandom, $urandom},
                            48'({$urandom, $urandom}));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b1;
        error_count = 0;
        push_idle_pct = 0;
        pop_stall_pct = 0;
        for (int n = 0; n < N_SLOTS; n++)
        begin
            shadow_key[n] = 64'd0;
            shadow_size[n] = 48'd0;
        end
        shadow_bytes = 64'd0;
        shadow_live = 13'd0;
        shadow_enable = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_enable(1'b1);
        add_request(CMD_RECORD, 64'd0, 48'd5);
        add_request(CMD_RELEASE, 64'd0, 48'd0);
        add_request(CMD_RELEASE, 64'h1234, 48'd0);
        add_request(CMD_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        add_request(CMD_RECORD, 64'h1, 48'h0);
        add_request(CMD_RECORD, 64'h1, 48'h7);
        add_request(CMD_RECORD, 64'h8000_0000_0000_0000, 48'h8000_0000_0000);
        add_request(CMD_RELEASE, 64'h1, 48'h0);
        add_request(CMD_RELEASE, 64'h1, 48'h0);
        add_request(CMD_RELEASE, 64'h1, 48'h0);
        add_request(CMD_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 48'h0);
        add_request(CMD_RECORD, 64'hAAAA_5555_AAAA_5555, 48'h5555_AAAA_5555);
        add_request(CMD_RECORD, 64'h5555_AAAA_5555_AAAA, 48'hAAAA_5555_AAAA);
        drain();

        write_enable(1'b0);
        add_request(CMD_RECORD, 64'h42, 48'h10);
        add_request(CMD_RELEASE, 64'h5555_AAAA_5555_AAAA, 48'h0);
        add_request(CMD_RECORD, 64'h0, 48'h0);
        drain();
        write_enable(1'b1);

        push_idle_pct = 0;
        pop_stall_pct = 0;
        random_phase(200, 64);
        drain();
        push_idle_pct = 58;
        random_phase(150, 12);
        drain();
        push_idle_pct = 0;
        pop_stall_pct = 58;
        random_phase(150, 64);
        drain();
        write_enable(1'b0);
        push_idle_pct = 29;
        pop_stall_pct = 29;
        random_phase(40, 64);
        drain();
        write_enable(1'b1);
        random_phase(250, 10);
        drain();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
hdl/alth_pkg.sv
hdl/alth_fifo.sv
hdl/alth_hash.sv
hdl/alth_front.sv
hdl/alth_back.sv
hdl/allocation_tracking_hash_table_unit.sv
tb/allocation_tracking_hash_table_unit_tb.sv
